// ===== hdl/serial_upload_frame_receiver_unit_macros.svh =====
// ----------------------------------------------------------------------------
// serial upload frame receiver assertion macros
// concurrent assertion wrappers on clk with asynchronous reset arst_n
// ----------------------------------------------------------------------------
`ifndef SERIAL_UPLOAD_FRAME_RECEIVER_UNIT_MACROS_SVH
`define SERIAL_UPLOAD_FRAME_RECEIVER_UNIT_MACROS_SVH

// same-cycle implication
`define SUFR_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SUFR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/sufr_pkg.sv =====
// ----------------------------------------------------------------------------
// sufr_pkg
// types and codes shared by the upload frame receiver and its interfaces
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sufr_pkg;

	typedef logic [1:0]  kind_t;
	typedef logic [3:0]  err_t;
	typedef logic [7:0]  byte_t;
	typedef logic [31:0] addr_t;
	typedef logic [15:0] chunk_t;
	typedef logic [1:0]  cfg_index_t;
	typedef logic [31:0] cfg_data_t;
	typedef logic [2:0]  phase_t;
	typedef logic [3:0]  digit_cnt_t;

	// command codes
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_BYTE  = 1'b1;

	// link characters
	localparam byte_t CH_SOH = 8'h01;
	localparam byte_t CH_ACK = 8'h06;
	localparam byte_t CH_ETB = 8'h17;
	localparam byte_t CH_EM  = 8'h19;

	// result kinds
	localparam kind_t KIND_WRITE = 2'd0;
	localparam kind_t KIND_SEND  = 2'd1;
	localparam kind_t KIND_DONE  = 2'd2;
	localparam kind_t KIND_ERROR = 2'd3;

	// error codes
	localparam err_t ERR_NONE       = 4'd0;
	localparam err_t ERR_BAD_TARGET = 4'd1;
	localparam err_t ERR_NO_SOH     = 4'd2;
	localparam err_t ERR_NO_SIZE_ETB = 4'd3;
	localparam err_t ERR_BAD_HEX    = 4'd4;
	localparam err_t ERR_ZERO       = 4'd5;
	localparam err_t ERR_TOO_BIG    = 4'd6;
	localparam err_t ERR_PAST_END   = 4'd7;
	localparam err_t ERR_NO_CHUNK_ETB = 4'd8;
	localparam err_t ERR_NO_EM      = 4'd9;

	// register indexes
	localparam cfg_index_t REG_TARGET_ADDRESS = 2'd0;
	localparam cfg_index_t REG_WINDOW_BEGIN   = 2'd1;
	localparam cfg_index_t REG_WINDOW_END     = 2'd2;
	localparam cfg_index_t REG_CHUNK_LENGTH   = 2'd3;

	// register reset values
	localparam addr_t  RST_TARGET_ADDRESS = 32'h8000_0000;
	localparam addr_t  RST_WINDOW_BEGIN   = 32'h8000_0000;
	localparam addr_t  RST_WINDOW_END     = 32'h8c00_0000;
	localparam chunk_t RST_CHUNK_LENGTH   = 16'd10240;

	localparam digit_cnt_t SIZE_DIGITS = 4'd8;

	// result record
	typedef struct packed {
		kind_t kind;
		addr_t address;
		byte_t value;
		err_t  error_code;
	} result_t;

	// ascii hex digit decode, valid flag in the top bit
	function automatic logic [4:0] hex_decode(input byte_t c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/sufr_req_if.sv =====
// ----------------------------------------------------------------------------
// sufr_req_if
// input channel: start command or one received byte
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sufr_req_if;
	logic            valid;
	logic            ready;
	logic            cmd;
	sufr_pkg::byte_t rx_byte;

	modport source (output valid, output cmd, output rx_byte, input ready);
	modport sink (input valid, input cmd, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== hdl/sufr_rsp_if.sv =====
// ----------------------------------------------------------------------------
// sufr_rsp_if
// result channel: memory write, byte to host, completion or error
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sufr_rsp_if;
	logic            valid;
	logic            ready;
	sufr_pkg::kind_t kind;
	sufr_pkg::addr_t address;
	sufr_pkg::byte_t value;
	sufr_pkg::err_t  error_code;

	modport source (output valid, output kind, output address, output value,
		output error_code, input ready);
	modport sink (input valid, input kind, input address, input value,
		input error_code, output ready);
endinterface

`default_nettype wire

// ===== hdl/serial_upload_frame_receiver_unit.sv =====
// a transaction accepted on req passes the input register and then the result register on its way to rsp
// throughput: one transaction per cycle while rsp takes results, set by the single decode pass between
//   the input register and the result register
// a result waiting on rsp holds the input register, so req stalls while it is full
// reset: arst_n clears the frame state to idle and loads the register defaults
// ----------------------------------------------------------------------------
// serial_upload_frame_receiver_unit
// frame decoder for a binary upload over a byte link: size header, range
// check, data bytes as memory writes, chunk acknowledges and completion
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module serial_upload_frame_receiver_unit (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cfg_write,
	input  sufr_pkg::cfg_index_t cfg_index,
	input  sufr_pkg::cfg_data_t  cfg_data,
	sufr_req_if.sink             req,
	sufr_rsp_if.source           rsp
);
	import sufr_pkg::*;

	// frame phases
	localparam phase_t PH_IDLE       = 3'd0;
	localparam phase_t PH_SOH        = 3'd1;
	localparam phase_t PH_DIGITS     = 3'd2;
	localparam phase_t PH_DIGITS_BAD = 3'd3;
	localparam phase_t PH_DATA       = 3'd4;
	localparam phase_t PH_CHUNK_ETB  = 3'd5;
	localparam phase_t PH_EM         = 3'd6;

	// configuration registers
	addr_t  target_address_q;
	addr_t  window_begin_q;
	addr_t  window_end_q;
	chunk_t chunk_length_q;

	// frame state
	phase_t     phase_q;
	addr_t      size_acc_q;
	digit_cnt_t digit_count_q;
	addr_t      bytes_remaining_q;
	chunk_t     chunk_count_q;
	addr_t      write_address_q;

	// input register
	logic  valid_s1;
	logic  cmd_s1;
	byte_t rx_byte_s1;

	// result register
	logic    out_valid_q;
	result_t result_q;

	logic advance;

	// next state and result from the decode pass
	phase_t     phase_n;
	addr_t      size_acc_n;
	digit_cnt_t digit_count_n;
	addr_t      bytes_remaining_n;
	chunk_t     chunk_count_n;
	addr_t      write_address_n;
	logic       res_valid;
	result_t    res;

	logic [4:0]  hex;
	addr_t       window_size;
	logic [32:0] end_sum;
	chunk_t      chunk_inc;
	addr_t       remaining_dec;

	// ---------------------------------------------------------------------
	// flow control: the input register moves on when the result slot is free
	// or being emptied in the same cycle
	// ---------------------------------------------------------------------
	assign advance   = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_s1     <= req.cmd;
			rx_byte_s1 <= req.rx_byte;
		end
	end

	// ---------------------------------------------------------------------
	// configuration writes
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_address_q <= RST_TARGET_ADDRESS;
			window_begin_q   <= RST_WINDOW_BEGIN;
			window_end_q     <= RST_WINDOW_END;
			chunk_length_q   <= RST_CHUNK_LENGTH;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_TARGET_ADDRESS: target_address_q <= cfg_data;
				REG_WINDOW_BEGIN:   window_begin_q   <= cfg_data;
				REG_WINDOW_END:     window_end_q     <= cfg_data;
				REG_CHUNK_LENGTH:   chunk_length_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// decode pass
	// ---------------------------------------------------------------------
	assign hex           = hex_decode(rx_byte_s1);
	// inverted or empty window counts as size zero
	assign window_size   = (window_end_q > window_begin_q) ? (window_end_q - window_begin_q)
		: '0;
	assign end_sum       = {1'b0, target_address_q} + {1'b0, size_acc_q};
	// a zero chunk length matches after the counter wraps, i.e. 65536 bytes
	assign chunk_inc     = chunk_count_q + 16'd1;
	assign remaining_dec = bytes_remaining_q - 32'd1;

	always_comb begin
		phase_n           = phase_q;
		size_acc_n        = size_acc_q;
		digit_count_n     = digit_count_q;
		bytes_remaining_n = bytes_remaining_q;
		chunk_count_n     = chunk_count_q;
		write_address_n   = write_address_q;
		res_valid         = 1'b0;
		res               = '0;

		if (cmd_s1 == CMD_START) begin
			// a start aborts anything in flight, then checks the target
			if (target_address_q < window_begin_q || target_address_q >= window_end_q) begin
				phase_n        = PH_IDLE;
				res_valid      = 1'b1;
				res.kind       = KIND_ERROR;
				res.error_code = ERR_BAD_TARGET;
			end else begin
				phase_n = PH_SOH;
			end
		end else begin
			unique case (phase_q)
				PH_SOH: begin
					if (rx_byte_s1 != CH_SOH) begin
						phase_n        = PH_IDLE;
						res_valid      = 1'b1;
						res.kind       = KIND_ERROR;
						res.value      = rx_byte_s1;
						res.error_code = ERR_NO_SOH;
					end else begin
						phase_n       = PH_DIGITS;
						size_acc_n    = '0;
						digit_count_n = '0;
					end
				end
				PH_DIGITS, PH_DIGITS_BAD: begin
					if (digit_count_q < SIZE_DIGITS) begin
						// a bad digit is remembered, the header is still taken whole
						if (!hex[4]) begin
							phase_n = PH_DIGITS_BAD;
						end else begin
							size_acc_n = {size_acc_q[27:0], hex[3:0]};
						end
						digit_count_n = digit_count_q + 4'd1;
					end else begin
						res_valid = 1'b1;
						res.kind  = KIND_ERROR;
						phase_n   = PH_IDLE;
						if (rx_byte_s1 != CH_ETB) begin
							res.value      = rx_byte_s1;
							res.error_code = ERR_NO_SIZE_ETB;
						end else if (phase_q == PH_DIGITS_BAD) begin
							res.error_code = ERR_BAD_HEX;
						end else if (size_acc_q == '0) begin
							res.error_code = ERR_ZERO;
						end else if (size_acc_q > window_size) begin
							res.error_code = ERR_TOO_BIG;
						end else if (end_sum >= {1'b0, window_end_q}) begin
							res.error_code = ERR_PAST_END;
						end else begin
							// header good: acknowledge and open the data phase
							res.kind          = KIND_SEND;
							res.value         = CH_ACK;
							bytes_remaining_n = size_acc_q;
							write_address_n   = target_address_q;
							chunk_count_n     = '0;
							phase_n           = PH_DATA;
						end
					end
				end
				PH_DATA: begin
					res_valid         = 1'b1;
					res.kind          = KIND_WRITE;
					res.address       = write_address_q;
					res.value         = rx_byte_s1;
					write_address_n   = write_address_q + 32'd1;
					bytes_remaining_n = remaining_dec;
					chunk_count_n     = chunk_inc;
					if (chunk_inc == chunk_length_q || remaining_dec == '0) begin
						phase_n = PH_CHUNK_ETB;
					end
				end
				PH_CHUNK_ETB: begin
					res_valid = 1'b1;
					if (rx_byte_s1 != CH_ETB) begin
						phase_n        = PH_IDLE;
						res.kind       = KIND_ERROR;
						res.value      = rx_byte_s1;
						res.error_code = ERR_NO_CHUNK_ETB;
					end else begin
						res.kind      = KIND_SEND;
						res.value     = CH_ACK;
						chunk_count_n = '0;
						phase_n       = (bytes_remaining_q == '0) ? PH_EM : PH_DATA;
					end
				end
				PH_EM: begin
					res_valid = 1'b1;
					phase_n   = PH_IDLE;
					if (rx_byte_s1 != CH_EM) begin
						res.kind       = KIND_ERROR;
						res.value      = rx_byte_s1;
						res.error_code = ERR_NO_EM;
					end else begin
						res.kind = KIND_DONE;
					end
				end
				default: ;	// bytes while idle are dropped
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// frame state update
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q           <= PH_IDLE;
			size_acc_q        <= '0;
			digit_count_q     <= '0;
			bytes_remaining_q <= '0;
			chunk_count_q     <= '0;
			write_address_q   <= '0;
		end else if (advance) begin
			phase_q           <= phase_n;
			size_acc_q        <= size_acc_n;
			digit_count_q     <= digit_count_n;
			bytes_remaining_q <= bytes_remaining_n;
			chunk_count_q     <= chunk_count_n;
			write_address_q   <= write_address_n;
		end
	end

	// ---------------------------------------------------------------------
	// result register
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_valid;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			result_q <= res;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.kind       = result_q.kind;
	assign rsp.address    = result_q.address;
	assign rsp.value      = result_q.value;
	assign rsp.error_code = result_q.error_code;

	// ---------------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------------
`include "serial_upload_frame_receiver_unit_macros.svh"

	`SUFR_ASSERT_SAME(a_data_has_bytes, phase_q == PH_DATA, bytes_remaining_q != '0, "data phase with nothing left")
	`SUFR_ASSERT_SAME(a_digit_bound, phase_q == PH_DIGITS || phase_q == PH_DIGITS_BAD, digit_count_q <= SIZE_DIGITS, "size digit count overrun")
	`SUFR_ASSERT_SAME(a_write_no_code, out_valid_q && result_q.kind != KIND_ERROR, result_q.error_code == ERR_NONE, "error code on a non-error result")
	`SUFR_ASSERT_SAME(a_addr_only_write, out_valid_q && result_q.kind != KIND_WRITE, result_q.address == '0, "address on a non-write result")
	`SUFR_ASSERT_NEXT(a_stage_hold, valid_s1 && !advance, valid_s1 && $stable(rx_byte_s1) && $stable(phase_q), "stalled input stage lost")

endmodule

`default_nettype wire

// ===== verif/tb_serial_upload_frame_receiver_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_serial_upload_frame_receiver_unit
// self-checking bench for the upload frame receiver: queued link traffic
// (well-formed uploads with random content, broken frames and idle noise)
// is driven through the request channel, every accepted transaction is run
// through a behavioural decoder, and each result is compared field by field
// against the oldest prediction; register settings change between phases
// ----------------------------------------------------------------------------

module tb_serial_upload_frame_receiver_unit;
	import sufr_pkg::*;

	// decoder phases of the behavioural copy
	typedef enum logic [2:0] {
		FS_IDLE,
		FS_SOH,
		FS_DIGITS,
		FS_DIGITS_BAD,
		FS_DATA,
		FS_CHUNK_ETB,
		FS_EM
	} frame_state_e;

	// ways an upload can be spoilt by the stimulus
	typedef enum int {
		FLT_NONE,
		FLT_SOH,
		FLT_HEX,
		FLT_SIZE_ETB,
		FLT_ZERO,
		FLT_CHUNK_ETB,
		FLT_EM,
		FLT_CUT,
		FLT_WILD_SIZE
	} upload_flaw_e;

	typedef struct packed {
		logic  cmd;
		byte_t rx_byte;
	} link_item_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_write;
	cfg_index_t cfg_index;
	cfg_data_t  cfg_data;

	sufr_req_if req_bus ();
	sufr_rsp_if rsp_bus ();

	serial_upload_frame_receiver_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_bus),
		.rsp       (rsp_bus)
	);

	// register copies, shared by the decoder copy and the frame builder
	addr_t  reg_target;
	addr_t  reg_wbegin;
	addr_t  reg_wend;
	chunk_t reg_chunk;

	// behavioural decoder state
	frame_state_e frame_st;
	addr_t        size_acc;
	digit_cnt_t   digits_seen;
	addr_t        bytes_left;
	chunk_t       chunk_fill;
	addr_t        next_addr;

	result_t    awaited_results[$];
	link_item_t link_backlog[$];

	int         fail_count = 0;
	int         items_queued = 0;
	int         phase_items = 0;
	int         phase_no;
	int         size_cap;
	int         send_gap = 0;
	int         sink_stall = 0;
	bit         req_taken = 1'b0;
	bit         no_idle = 1'b0;
	int         kind_tally[4] = '{0, 0, 0, 0};
	logic [15:0] codes_seen = '0;

	// 4 ns clock
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// --------------------------------------------------------------------
	// behavioural decoder
	// --------------------------------------------------------------------

	function automatic int nibble_of(input byte_t c);
		if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
		if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
		if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
		return -1;
	endfunction

	function automatic void await_result(input kind_t k, input addr_t a, input byte_t v,
		input err_t e);
		result_t r;
		r.kind = k;
		r.address = a;
		r.value = v;
		r.error_code = e;
		awaited_results.push_back(r);
	endfunction

	// every fault drops the decoder back to idle
	function automatic void await_fault(input byte_t v, input err_t e);
		frame_st = FS_IDLE;
		await_result(KIND_ERROR, '0, v, e);
	endfunction

	function automatic void decode_link_byte(input logic cmd, input byte_t b);
		int          nib;
		addr_t       span;
		logic [32:0] reach;
		// a start aborts whatever was going on and checks the target
		if (cmd == CMD_START) begin
			if (reg_target < reg_wbegin || reg_target >= reg_wend)
				await_fault(8'h00, ERR_BAD_TARGET);
			else
				frame_st = FS_SOH;
			return;
		end
		case (frame_st)
			FS_SOH: begin
				if (b != CH_SOH) begin
					await_fault(b, ERR_NO_SOH);
				end else begin
					frame_st = FS_DIGITS;
					size_acc = '0;
					digits_seen = '0;
				end
			end
			FS_DIGITS, FS_DIGITS_BAD: begin
				if (digits_seen < SIZE_DIGITS) begin
					// a bad digit is only reported once the size ETB is in
					nib = nibble_of(b);
					if (nib < 0)
						frame_st = FS_DIGITS_BAD;
					else
						size_acc = {size_acc[27:0], nib[3:0]};
					digits_seen = digits_seen + 1'b1;
				end else if (b != CH_ETB) begin
					await_fault(b, ERR_NO_SIZE_ETB);
				end else if (frame_st == FS_DIGITS_BAD) begin
					await_fault(8'h00, ERR_BAD_HEX);
				end else if (size_acc == 0) begin
					await_fault(8'h00, ERR_ZERO);
				end else begin
					// inverted or empty window counts as size zero
					span = (reg_wend > reg_wbegin) ? reg_wend - reg_wbegin : '0;
					reach = {1'b0, reg_target} + {1'b0, size_acc};
					if (size_acc > span) begin
						await_fault(8'h00, ERR_TOO_BIG);
					end else if (reach >= {1'b0, reg_wend}) begin
						await_fault(8'h00, ERR_PAST_END);
					end else begin
						bytes_left = size_acc;
						next_addr = reg_target;
						chunk_fill = '0;
						frame_st = FS_DATA;
						await_result(KIND_SEND, '0, CH_ACK, ERR_NONE);
					end
				end
			end
			FS_DATA: begin
				await_result(KIND_WRITE, next_addr, b, ERR_NONE);
				next_addr = next_addr + 1'b1;
				bytes_left = bytes_left - 1'b1;
				// 16-bit count, so a chunk length of zero means 65536
				chunk_fill = chunk_fill + 1'b1;
				if (chunk_fill == reg_chunk || bytes_left == 0)
					frame_st = FS_CHUNK_ETB;
			end
			FS_CHUNK_ETB: begin
				if (b != CH_ETB) begin
					await_fault(b, ERR_NO_CHUNK_ETB);
				end else begin
					chunk_fill = '0;
					frame_st = (bytes_left == 0) ? FS_EM : FS_DATA;
					await_result(KIND_SEND, '0, CH_ACK, ERR_NONE);
				end
			end
			FS_EM: begin
				if (b != CH_EM) begin
					await_fault(b, ERR_NO_EM);
				end else begin
					frame_st = FS_IDLE;
					await_result(KIND_DONE, '0, 8'h00, ERR_NONE);
				end
			end
			default: ; // bytes while idle are dropped
		endcase
	endfunction

	// --------------------------------------------------------------------
	// rising edge: result check first, then prediction of the new transaction
	// --------------------------------------------------------------------
	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n) begin
			if (rsp_bus.valid && rsp_bus.ready) begin
				if (awaited_results.size() == 0) begin
					$error("unexpected result: kind %0d address %h value %h error_code %0d",
						rsp_bus.kind, rsp_bus.address, rsp_bus.value, rsp_bus.error_code);
					fail_count++;
				end else begin
					want = awaited_results.pop_front();
					if (rsp_bus.kind !== want.kind) begin
						$error("kind: expected %0d, got %0d", want.kind, rsp_bus.kind);
						fail_count++;
					end
					if (rsp_bus.address !== want.address) begin
						$error("address: expected %h, got %h", want.address, rsp_bus.address);
						fail_count++;
					end
					if (rsp_bus.value !== want.value) begin
						$error("value: expected %h, got %h", want.value, rsp_bus.value);
						fail_count++;
					end
					if (rsp_bus.error_code !== want.error_code) begin
						$error("error_code: expected %0d, got %0d", want.error_code,
							rsp_bus.error_code);
						fail_count++;
					end
					kind_tally[want.kind]++;
					if (want.kind == KIND_ERROR)
						codes_seen[want.error_code] = 1'b1;
				end
				// stall drawn per result
				sink_stall = no_idle ? 0 : $urandom_range(0, 15);
			end
			if (req_bus.valid && req_bus.ready) begin
				decode_link_byte(req_bus.cmd, req_bus.rx_byte);
				req_taken = 1'b1;
			end
		end
	end

	// --------------------------------------------------------------------
	// falling edge: request driver and result-side back-pressure
	// --------------------------------------------------------------------
	always @(negedge clk) begin : link_driver
		link_item_t nxt;
		// an offered transaction stays put until it is taken
		if (!(req_bus.valid && !req_taken)) begin
			req_taken = 1'b0;
			if (send_gap > 0) begin
				send_gap--;
				req_bus.valid <= 1'b0;
			end else if (link_backlog.size() != 0) begin
				nxt = link_backlog.pop_front();
				req_bus.valid <= 1'b1;
				req_bus.cmd <= nxt.cmd;
				req_bus.rx_byte <= nxt.rx_byte;
				// gap drawn per transaction, spent after it is accepted
				send_gap = no_idle ? 0 : $urandom_range(0, 15);
			end else begin
				req_bus.valid <= 1'b0;
			end
		end
		if (sink_stall > 0) begin
			sink_stall--;
			rsp_bus.ready <= 1'b0;
		end else begin
			rsp_bus.ready <= 1'b1;
		end
	end

	// --------------------------------------------------------------------
	// stimulus helpers
	// --------------------------------------------------------------------

	task automatic queue_item(input logic cmd, input byte_t b, input bit counted);
		link_item_t it;
		it.cmd = cmd;
		it.rx_byte = b;
		link_backlog.push_back(it);
		if (counted) begin
			items_queued++;
			phase_items++;
		end
	endtask

	function automatic byte_t byte_other_than(input byte_t avoid);
		byte_t b;
		do begin
			b = byte_t'($urandom);
		end while (b == avoid);
		return b;
	endfunction

	function automatic byte_t non_hex_byte();
		byte_t b;
		do begin
			b = byte_t'($urandom);
		end while (nibble_of(b) >= 0);
		return b;
	endfunction

	// letters come in either case
	function automatic byte_t hex_char(input logic [3:0] n);
		if (n < 4'd10) return 8'h30 + {4'h0, n};
		if ($urandom_range(0, 1) != 0) return 8'h41 + {4'h0, n - 4'd10};
		return 8'h61 + {4'h0, n - 4'd10};
	endfunction

	// one upload: start, SOH, size digits, ETB, data in chunks, EM, possibly spoilt
	task automatic queue_upload();
		byte_t        frame[$];
		int           etb_at[$];
		upload_flaw_e flaw;
		int           draw;
		int           keep;
		int           pick;
		int           fill;
		int           data_len;
		logic [31:0]  size;
		logic [31:0]  chunk_span;
		// refused start: the block stays idle, so keep it short
		if (reg_target < reg_wbegin || reg_target >= reg_wend) begin
			queue_item(CMD_START, byte_t'($urandom), 1'b1);
			queue_item(CMD_BYTE, CH_SOH, 1'b0);
			return;
		end
		draw = $urandom_range(0, 12);
		flaw = (draw <= 8) ? upload_flaw_e'(draw) : FLT_NONE;
		if (flaw == FLT_ZERO)
			size = '0;
		else if (flaw == FLT_WILD_SIZE)
			size = $urandom;
		else
			size = $urandom_range(1, size_cap);
		data_len = (flaw == FLT_ZERO || flaw == FLT_WILD_SIZE) ? 0 : int'(size);
		chunk_span = (reg_chunk == 0) ? 32'h0001_0000 : {16'h0000, reg_chunk};

		frame.push_back(CH_SOH);
		for (int i = 7; i >= 0; i--)
			frame.push_back(hex_char(size[4*i +: 4]));
		frame.push_back(CH_ETB);
		fill = 0;
		for (int i = 0; i < data_len; i++) begin
			frame.push_back(byte_t'($urandom));
			fill++;
			if (fill == chunk_span || i == data_len - 1) begin
				etb_at.push_back(frame.size());
				frame.push_back(CH_ETB);
				fill = 0;
			end
		end
		frame.push_back(CH_EM);
		keep = frame.size();

		case (flaw)
			FLT_SOH: begin
				frame[0] = byte_other_than(CH_SOH);
				keep = 1;
			end
			FLT_HEX: begin
				frame[$urandom_range(1, 8)] = non_hex_byte();
				// sometimes the size ETB is wrong as well, which wins
				if ($urandom_range(0, 1) != 0)
					frame[9] = byte_other_than(CH_ETB);
				keep = 10;
			end
			FLT_SIZE_ETB: begin
				frame[9] = byte_other_than(CH_ETB);
				keep = 10;
			end
			FLT_ZERO, FLT_WILD_SIZE: keep = 10;
			FLT_CHUNK_ETB: begin
				pick = etb_at[$urandom_range(0, etb_at.size() - 1)];
				frame[pick] = byte_other_than(CH_ETB);
				keep = pick + 1;
			end
			FLT_EM: frame[keep - 1] = byte_other_than(CH_EM);
			// cut short; the next start aborts it silently
			FLT_CUT: keep = $urandom_range(1, frame.size() - 1);
			default: ;
		endcase

		queue_item(CMD_START, byte_t'($urandom), 1'b1);
		for (int i = 0; i < keep; i++)
			queue_item(CMD_BYTE, frame[i], 1'b1);
	endtask

	task automatic write_register(input cfg_index_t idx, input cfg_data_t data);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_TARGET_ADDRESS: reg_target = data;
			REG_WINDOW_BEGIN:   reg_wbegin = data;
			REG_WINDOW_END:     reg_wend = data;
			REG_CHUNK_LENGTH:   reg_chunk = data[15:0];
			default: ;
		endcase
	endtask

	// all sent, all answered, then wait out transactions still in flight that give no result
	task automatic wait_until_quiet();
		while (link_backlog.size() != 0 || req_bus.valid || awaited_results.size() != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	// register settings per phase: fixed corners first, then random windows
	task automatic pick_settings(input int p);
		addr_t       t;
		addr_t       wb;
		addr_t       we;
		chunk_t      cl;
		logic [31:0] span;
		case (p)
			1: begin // small window, too-big and past-end sizes
				t = 32'h0000_1000; wb = 32'h0000_1000; we = 32'h0000_1040;
				cl = 16'd4; size_cap = 80;
			end
			2: begin // widest window, target near the top, one byte per chunk
				t = 32'hFFFF_FFE0; wb = 32'h0000_0000; we = 32'hFFFF_FFFF;
				cl = 16'd1; size_cap = 40;
			end
			3: begin // lowest target, longest chunk
				t = 32'h0000_0000; wb = 32'h0000_0000; we = 32'hFFFF_FFFF;
				cl = 16'hFFFF; size_cap = 40;
			end
			4: begin // chunk length zero
				t = 32'h7FFF_FFF0; wb = 32'h7FFF_FFF0; we = 32'h8000_0010;
				cl = 16'd0; size_cap = 48;
			end
			5: begin // inverted window
				t = 32'h0000_1234; wb = 32'hFFFF_FFFF; we = 32'h0000_0000;
				cl = 16'd7; size_cap = 8;
			end
			6: begin // empty window
				t = 32'h0000_5000; wb = 32'h0000_5000; we = 32'h0000_5000;
				cl = 16'd3; size_cap = 8;
			end
			7: begin // target just below the window
				t = 32'h0000_0FFF; wb = 32'h0000_1000; we = 32'h0000_2000;
				cl = 16'd5; size_cap = 8;
			end
			8: begin // target at the window end
				t = 32'h0000_2000; wb = 32'h0000_1000; we = 32'h0000_2000;
				cl = 16'd5; size_cap = 8;
			end
			9: begin // top of the address space
				t = 32'hFFFF_FFF8; wb = 32'hFFFF_FFF0; we = 32'hFFFF_FFFF;
				cl = 16'd2; size_cap = 10;
			end
			default: begin
				span = $urandom_range(1, 200);
				wb = $urandom;
				if (wb > 32'hFFFF_FFFF - span)
					wb = 32'hFFFF_FFFF - span;
				we = wb + span;
				t = wb + $urandom_range(0, span - 1);
				cl = chunk_t'($urandom_range(1, 16));
				size_cap = (span + 8 > 64) ? 64 : span + 8;
			end
		endcase
		write_register(REG_WINDOW_BEGIN, wb);
		write_register(REG_WINDOW_END, we);
		write_register(REG_TARGET_ADDRESS, t);
		write_register(REG_CHUNK_LENGTH, {16'h0000, cl});
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	// --------------------------------------------------------------------
	// sequence
	// --------------------------------------------------------------------
	initial begin
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = REG_TARGET_ADDRESS;
		cfg_data = '0;
		req_bus.valid = 1'b0;
		req_bus.cmd = CMD_START;
		req_bus.rx_byte = '0;
		rsp_bus.ready = 1'b0;

		reg_target = RST_TARGET_ADDRESS;
		reg_wbegin = RST_WINDOW_BEGIN;
		reg_wend = RST_WINDOW_END;
		reg_chunk = RST_CHUNK_LENGTH;
		frame_st = FS_IDLE;
		size_acc = '0;
		digits_seen = '0;
		bytes_left = '0;
		chunk_fill = '0;
		next_addr = '0;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed opening at the reset settings
		size_cap = 24;
		queue_item(CMD_BYTE, 8'hA5, 1'b0);      // byte while idle, dropped
		queue_item(CMD_START, 8'hFF, 1'b1);
		queue_item(CMD_BYTE, CH_SOH, 1'b1);
		for (int i = 0; i < 7; i++)
			queue_item(CMD_BYTE, 8'h30, 1'b1);
		queue_item(CMD_BYTE, 8'h32, 1'b1);      // size two
		queue_item(CMD_BYTE, CH_ETB, 1'b1);
		queue_item(CMD_BYTE, 8'h00, 1'b1);      // data extremes
		queue_item(CMD_BYTE, 8'hFF, 1'b1);
		queue_item(CMD_BYTE, CH_ETB, 1'b1);     // last chunk acknowledged
		queue_item(CMD_BYTE, CH_EM, 1'b1);      // completion
		queue_item(CMD_START, 8'h00, 1'b1);
		queue_item(CMD_BYTE, 8'h55, 1'b1);      // missing SOH
		queue_item(CMD_START, 8'h80, 1'b1);
		queue_item(CMD_BYTE, CH_SOH, 1'b1);
		queue_item(CMD_BYTE, 8'h66, 1'b1);
		queue_item(CMD_START, 8'h7F, 1'b1);     // abort in the middle of the size
		queue_item(CMD_BYTE, CH_SOH, 1'b1);

		// random uploads, one register setting per phase
		for (phase_no = 0; items_queued < 1050; phase_no++) begin
			if (phase_no > 0) begin
				// sender holds off until every result is in, then reprogrammes
				wait_until_quiet();
				pick_settings(phase_no);
			end
			no_idle = (phase_no % 4 == 3) || ($urandom_range(0, 5) == 0);
			phase_items = 0;
			while (phase_items < 70) begin
				if ($urandom_range(0, 9) == 0)
					queue_item(CMD_BYTE, byte_t'($urandom), 1'b0);
				queue_upload();
			end
		end

		wait_until_quiet();
		$display("covered %0d link transactions over %0d register settings",
			items_queued, phase_no);
		$display("checked %0d writes, %0d acks, %0d completions, %0d errors (codes seen %b)",
			kind_tally[KIND_WRITE], kind_tally[KIND_SEND], kind_tally[KIND_DONE],
			kind_tally[KIND_ERROR], codes_seen[9:1]);
		if (fail_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
